/* src/fet_pkg.sv */
// Shared constants and types for the FIFO eviction tracker
`timescale 1ns / 1ps
package fet_pkg;

  localparam int ID_W      = 64;
  localparam int CAP_W     = 5;
  localparam int DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic cmp;   // register id match
    logic rm;    // remove: close the gap at the matching cell
    logic ev;    // evict: whole row moves one place towards the old end
    logic ins;   // load the new id at the insert position
  } cell_ctl_t;

endpackage

/* src/fet_in_if.sv */
// Input channel: access or remove item
`timescale 1ns / 1ps
interface fet_in_if
  import fet_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            action;
  logic [ID_W-1:0] object_id;

  modport source (output valid, output action, output object_id, input ready);
  modport sink   (input valid, input action, input object_id, output ready);
endinterface

/* src/fet_out_if.sv */
// Output channel: eviction result item
`timescale 1ns / 1ps
interface fet_out_if
  import fet_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            evict_valid;
  logic [ID_W-1:0] evicted_id;

  modport source (output valid, output evict_valid, output evicted_id, input ready);
  modport sink   (input valid, input evict_valid, input evicted_id, output ready);
endinterface

/* src/fifo_eviction_tracker_core.sv */
// FIFO eviction tracker: sequencer, capacity register and row of id cells
//
//   channel  dir  payload                   handshake
//   req      in   action, object_id         valid/ready
//   rsp      out  evict_valid, evicted_id   valid/ready
//   cfg      in   capacity (5 bits)         cfg_we, no back-pressure
//
// Each item passes through three states: accept, compare in all cells, update the row.
// The update waits while the result register is still full; a new item is
// taken as soon as the update has been written, even if the result waits.
// rst (synchronous) empties the row and sets capacity to 16.
// Remove shifts ripple through the cell chain in the update cycle.
`timescale 1ns / 1ps
module fifo_eviction_tracker_core
  import fet_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  fet_in_if.sink           req,
  fet_out_if.source        rsp
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             op;
  logic [ID_W-1:0]  cur_id;

  cell_ctl_t        ctl;
  logic [CW-1:0]    ins_idx;
  logic [ID_W-1:0]  cell_id [DEPTH];
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH:0]   shift_chain;

  logic             hit;
  logic             is_rm;
  logic             full;
  logic             fire;
  logic [EW-1:0]    cap_e;
  logic [EW-1:0]    cap_eff;
  logic             res_ev;
  logic [ID_W-1:0]  res_id;

  assign req.ready = (state == S_IDLE);

  assign hit     = |match_vec;
  assign is_rm   = (op == ACT_REMOVE);
  assign cap_e   = EW'(capacity);
  assign cap_eff = (cap_e > DEPTH_E) ? DEPTH_E : cap_e;
  assign full    = EW'(count) >= cap_eff;
  assign fire    = (state == S_UPD) && (!rsp.valid || rsp.ready);

  assign res_ev  = !is_rm && !hit && full;
  assign res_id  = (count == '0) ? cur_id : cell_id[0];

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.rm  = fire && is_rm && hit;
    ctl.ev  = fire && res_ev && (count != '0);
    // capacity zero: the new id is reported straight away, nothing stored
    ctl.ins = fire && !is_rm && !hit && (!full || (count != '0));
    ins_idx = full ? (count - CW'(1)) : count;
  end

  always_comb begin
    count_next = count;
    if (ctl.rm) begin
      count_next = count - CW'(1);
    end else if (ctl.ins && !full) begin
      count_next = count + CW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_CMP;
      S_CMP:   state_next = S_UPD;
      S_UPD:   if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAP_RESET;
      count    <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op     <= req.action;
      cur_id <= req.object_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.evict_valid <= res_ev;
      rsp.evicted_id  <= res_ev ? res_id : '0;
    end
  end

  assign shift_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_id[i+1];
    end

    fet_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (count),
      .ins_idx   (ins_idx),
      .new_id    (cur_id),
      .nbr_id    (nbr),
      .shift_in  (shift_chain[i]),
      .shift_out (shift_chain[i+1]),
      .id        (cell_id[i]),
      .match     (match_vec[i])
    );
  end

  // ids are never held twice, so at most one cell can match
  a_one_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> $onehot0(match_vec))
    else $error("more than one cell matched the id");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(count) <= DEPTH_E)
    else $error("held count beyond depth");

  a_rm_no_evict: assert property (@(posedge clk) disable iff (rst)
    (fire && is_rm) |=> (rsp.valid && !rsp.evict_valid))
    else $error("remove item reported an eviction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_UPD) |=> $stable(count))
    else $error("held count changed outside the update cycle");

endmodule

/* src/fet_cell.sv */
// One slot of the held-id row: stores an id, compares it and shifts
`timescale 1ns / 1ps
module fet_cell
  import fet_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cell_ctl_t                  ctl,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic [$clog2(DEPTH+1)-1:0] ins_idx,
  input  logic [ID_W-1:0]            new_id,
  input  logic [ID_W-1:0]            nbr_id,
  input  logic                       shift_in,
  output logic                       shift_out,
  output logic [ID_W-1:0]            id,
  output logic                       match
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] MY = CW'(IDX);

  logic active;
  logic take_nbr;

  assign active    = count > MY;
  assign shift_out = shift_in | match;
  // on remove, every cell from the matching one upwards takes its neighbour
  assign take_nbr  = ctl.ev | (ctl.rm & (shift_in | match));

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.cmp) begin
      match <= active && (id == new_id);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && (ins_idx == MY)) begin
      id <= new_id;
    end else if (take_nbr) begin
      id <= nbr_id;
    end
  end

endmodule
